[src/dswt_pkg.sv]
// package for the duplicate sequence-number window table
// shared types and constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dswt_pkg;
    localparam int SeqW  = 64;
    localparam int WinW  = 32;
    localparam int MetaW = 24;

    // configuration register indexes
    localparam logic REG_SEQ_WIDTH = 1'b0;
    localparam logic REG_TOO_OLD   = 1'b1;

    typedef enum logic [1:0] {
        CMD_ADD  = 2'd0,
        CMD_TEST = 2'd1,
        CMD_TICK = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        V_OLD    = 3'd0,
        V_DUP    = 3'd1,
        V_CUR    = 3'd2,
        V_NEW    = 3'd3,
        V_NEWEST = 3'd4,
        V_FIRST  = 3'd5
    } t_verdict;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_CLASS,
        S_WRITE,
        S_OUT
    } t_state;

    // one table entry as stored in memory
    typedef struct packed {
        logic [63:0]      addr_high;
        logic [63:0]      addr_low;
        logic [MetaW-1:0] meta;
        logic [SeqW-1:0]  newest;
        logic [WinW-1:0]  window;
        logic [7:0]       stale;
        logic [63:0]      expiry;
    } t_entry;

    function automatic logic [SeqW-1:0] width_mask(input logic [1:0] mode);
        logic [SeqW-1:0] m;
        case (mode)
            2'd0:    m = 64'hFF;
            2'd1:    m = 64'hFFFF;
            2'd2:    m = 64'hFFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction
endpackage
`default_nettype wire

[src/dswt_class.sv]
// window classification of one sequence number against a table entry
// combinational; uses dswt_pkg
`timescale 1ns / 1ps
`default_nettype none
module dswt_class (
    input  wire  dswt_pkg::t_entry   i_ent,
    input  wire  logic [63:0]        i_seq,
    input  wire  logic [1:0]         i_mode,
    input  wire  logic [7:0]         i_limit,
    input  wire  logic               i_add,
    output dswt_pkg::t_entry         o_ent,
    output dswt_pkg::t_verdict       o_verdict
);
    import dswt_pkg::*;
    logic [63:0] mask, cur, d, mag, half;
    logic        neg;
    logic [7:0]  stale_inc;
    logic [WinW-1:0] bit_sel;

    always_comb begin
        mask = width_mask(i_mode);
        cur  = i_ent.newest & mask;
        d    = (i_seq - cur) & mask;
        half = mask >> 1;
        neg  = (i_mode == 2'd3) ? d[63] : (d > half);
        mag  = neg ? ((0 - d) & mask) : d;
        stale_inc = (i_ent.stale != 8'hFF) ? i_ent.stale + 8'd1 : i_ent.stale;
        bit_sel = WinW'(1) << mag[4:0];
        o_ent = i_ent;
        o_verdict = V_NEWEST;
        if (i_seq == cur) begin
            o_verdict = V_CUR;
        end else if (neg && mag > 64'd31) begin
            o_ent.stale = stale_inc;
            if (stale_inc > i_limit) begin
                o_ent.window = WinW'(1);
                o_ent.stale  = '0;
                o_ent.newest = i_seq;
                o_verdict    = V_NEWEST;
            end else begin
                o_verdict = V_OLD;
            end
        end else if (neg) begin
            o_ent.stale = '0;
            if ((i_ent.window & bit_sel) != '0) begin
                o_verdict = V_DUP;
            end else begin
                o_verdict = V_NEW;
                if (i_add) o_ent.window = i_ent.window | bit_sel;
            end
        end else begin
            o_ent.stale = '0;
            o_verdict = V_NEWEST;
            if (i_add) begin
                o_ent.newest = i_seq;
                if (mag >= 64'(WinW)) o_ent.window = WinW'(1);
                else o_ent.window = (i_ent.window << mag[4:0]) | WinW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[src/duplicate_seqno_window_table_core.sv]
// top level of the duplicate sequence-number window table
// uses dswt_pkg and dswt_class; entry store is a one-port-read synchronous ram
// an add or test request scans every entry for its key, then reads, classifies and writes back;
// the key scan reads one entry per cycle, and the result is held until it is taken
// one request at a time, next taken the cycle after the result is taken; a tick stays in idle
// reset: synchronous active low; clears used bits, time and control, loads config defaults
`timescale 1ns / 1ps
`default_nettype none
module duplicate_seqno_window_table_core #(
    parameter int TABLE_ENTRIES = 64
) (
    input  wire  logic         i_clk,
    input  wire  logic         i_rst_n,
    input  wire  logic         s_axis_tvalid,
    output logic               s_axis_tready,
    // tdata: command[1:0] msg_class[9:2] addr_high[73:10] addr_low[137:74]
    // addr_kind[145:138] prefix_len[153:146] seqno[217:154] valid_time[249:218]
    input  wire  logic [255:0] s_axis_tdata,
    output logic               m_axis_tvalid,
    input  wire  logic         m_axis_tready,
    // tdata: verdict[2:0]
    output logic [7:0]         m_axis_tdata,
    input  wire  logic         i_cfg_we,
    input  wire  logic         i_cfg_idx,
    input  wire  logic [7:0]   i_cfg_data
);
    import dswt_pkg::*;
    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_entry mem [TABLE_ENTRIES];
    t_entry r_rd;
    logic   r_rd_used;
    logic [TABLE_ENTRIES-1:0] r_used;

    t_state r_state, n_state;
    logic [1:0]  r_mode;
    logic [7:0]  r_limit;
    logic [63:0] r_now;
    logic [CW-1:0] r_idx;       // address being read
    logic [CW-1:0] r_cmp;       // address of entry in r_rd
    logic        r_hit_found, r_free_found;
    logic [AW-1:0] r_hit, r_free;
    logic        r_add;
    logic [63:0] r_ah, r_al, r_seq;
    logic [MetaW-1:0] r_meta;
    logic [31:0] r_vt;
    t_verdict    r_verdict;
    t_entry      r_wr;
    logic        r_we;
    logic [AW-1:0] r_wa;

    logic [AW-1:0] rd_addr;
    logic          rd_en, acc_in, live, match;
    t_entry        cls_ent;
    t_entry        hit_wr;
    t_verdict      cls_v;
    logic [64:0]   exp_sum;
    logic [63:0]   exp_new;

    assign acc_in = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_verdict};

    // ram: one read, one write port, registered read; used bit read alongside
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_wa] <= r_wr;
        if (rd_en) begin
            r_rd      <= mem[rd_addr];
            r_rd_used <= r_used[rd_addr];
        end
    end

    assign live  = r_rd_used && (r_rd.expiry > r_now);
    assign match = (r_rd.addr_high == r_ah) && (r_rd.addr_low == r_al) &&
                   (r_rd.meta == r_meta);
    assign exp_sum = {1'b0, r_now} + {33'd0, r_vt};
    assign exp_new = exp_sum[64] ? '1 : exp_sum[63:0];

    dswt_class u_class (
        .i_ent(r_rd), .i_seq(r_seq), .i_mode(r_mode), .i_limit(r_limit),
        .i_add(r_add), .o_ent(cls_ent), .o_verdict(cls_v)
    );

    // write-back entry on a hit; add with new or newest renews expiry
    always_comb begin
        hit_wr = cls_ent;
        if (r_add && (cls_v == V_NEW || cls_v == V_NEWEST)) hit_wr.expiry = exp_new;
    end

    always_comb begin
        rd_en = 1'b0;
        rd_addr = r_idx[AW-1:0];
        if (r_state == S_SCAN && r_idx < CW'(TABLE_ENTRIES)) rd_en = 1'b1;
        if (r_state == S_READ) begin
            rd_en = 1'b1;
            rd_addr = r_hit;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (acc_in && (s_axis_tdata[1:0] == CMD_ADD ||
                                    s_axis_tdata[1:0] == CMD_TEST)) n_state = S_SCAN;
            S_SCAN:  if (r_cmp == CW'(TABLE_ENTRIES - 1) && r_idx != '0) n_state = S_READ;
            S_READ:  n_state = S_CLASS;
            S_CLASS: n_state = S_WRITE;
            S_WRITE: n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= 2'd1;
            r_limit <= 8'd16;
            r_now <= '0;
            r_used <= '0;
            r_we <= 1'b0;
            r_idx <= '0;
            r_cmp <= '0;
        end else begin
            r_state <= n_state;
            r_we <= 1'b0;
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_SEQ_WIDTH) r_mode <= i_cfg_data[1:0];
                else r_limit <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: if (acc_in) begin
                    if (s_axis_tdata[1:0] == CMD_TICK && r_now != '1)
                        r_now <= r_now + 64'd1;
                    r_add  <= (s_axis_tdata[1:0] == CMD_ADD);
                    r_meta <= {s_axis_tdata[9:2], s_axis_tdata[145:138],
                               s_axis_tdata[153:146]};
                    r_ah   <= s_axis_tdata[73:10];
                    r_al   <= s_axis_tdata[137:74];
                    r_seq  <= s_axis_tdata[217:154] & width_mask(r_mode);
                    r_vt   <= s_axis_tdata[249:218];
                    r_idx  <= '0;
                    r_cmp  <= '0;
                    r_hit_found <= 1'b0;
                    r_free_found <= 1'b0;
                end
                S_SCAN: begin
                    r_idx <= r_idx + CW'(1);
                    r_cmp <= r_idx;
                    if (r_idx != '0) begin
                        if (live) begin
                            if (!r_hit_found && match) begin
                                r_hit_found <= 1'b1;
                                r_hit <= r_cmp[AW-1:0];
                            end
                        end else if (!r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free <= r_cmp[AW-1:0];
                        end
                    end
                end
                S_CLASS: begin
                    if (!r_hit_found) begin
                        r_verdict <= V_FIRST;
                        if (r_add) begin
                            if (!r_free_found) r_verdict <= V_OLD;
                            else begin
                                r_we <= 1'b1;
                                r_wa <= r_free;
                                r_used[r_free] <= 1'b1;
                                r_wr <= '{addr_high: r_ah, addr_low: r_al, meta: r_meta,
                                          newest: r_seq, window: WinW'(1), stale: 8'd0,
                                          expiry: exp_new};
                            end
                        end
                    end else begin
                        r_verdict <= cls_v;
                        r_we <= 1'b1;
                        r_wa <= r_hit;
                        r_wr <= hit_wr;
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("both sides active");
    a_write_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_we |-> r_state == S_WRITE) else $error("write outside write step");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(r_verdict))
        else $error("result lost");
`endif
endmodule
`default_nettype wire
